/* rtl/core/assert_macros.svh */
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);
`endif

/* rtl/core/pect_pkg.sv */
// ----------------------------------------------------------------------------
// pect_pkg
// Shared types and codes of the ear clipping triangulator.
// ----------------------------------------------------------------------------
`default_nettype none
package pect_pkg;
  typedef enum logic [1:0] {
    ST_TRI = 2'd0, ST_FEW = 2'd1, ST_NOEAR = 2'd2, ST_OVER = 2'd3
  } status_e;

  // Cell control: shift the ring by one, load a vertex at the tail, drop the second vertex.
  typedef struct packed {
    logic shift;
    logic load;
    logic drop;
  } cell_ctl_t;
endpackage
`default_nettype wire

/* rtl/core/pect_if.sv */
// ----------------------------------------------------------------------------
// pect_vtx_if / pect_tri_if
// Valid/ready channels for vertex and triangle items.
// ----------------------------------------------------------------------------
`default_nettype none
interface pect_vtx_if #(parameter int CW = 16);
  logic valid;
  logic ready;
  logic signed [CW-1:0] x_coord;
  logic signed [CW-1:0] y_coord;
  logic last_vertex;
  modport source (output valid, x_coord, y_coord, last_vertex, input ready);
  modport sink (input valid, x_coord, y_coord, last_vertex, output ready);
endinterface

interface pect_tri_if #(parameter int CW = 16);
  logic valid;
  logic ready;
  logic signed [CW-1:0] ax, ay, bx, by, cx, cy;
  logic last_triangle;
  logic [1:0] status;
  modport source (output valid, ax, ay, bx, by, cx, cy, last_triangle, status,
                  input ready);
  modport sink (input valid, ax, ay, bx, by, cx, cy, last_triangle, status,
                output ready);
endinterface
`default_nettype wire

/* rtl/core/pect_cell.sv */
// ----------------------------------------------------------------------------
// pect_cell
// One slot of the vertex ring; passes its vertex to the neighbor on shift.
// ----------------------------------------------------------------------------
`default_nettype none
module pect_cell
  import pect_pkg::*;
#(
  parameter int CW = 16
) (
  input  wire logic clk_i,
  input  wire cell_ctl_t ctl_i,
  input  wire logic signed [CW-1:0] x_i,
  input  wire logic signed [CW-1:0] y_i,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o
);
  logic signed [CW-1:0] x_q, y_q;
  always_ff @(posedge clk_i) begin
    if (ctl_i.shift || ctl_i.load || ctl_i.drop) begin
      x_q <= x_i;
      y_q <= y_i;
    end
  end
  assign x_o = x_q;
  assign y_o = y_q;
endmodule
`default_nettype wire

/* rtl/core/polygon_ear_clip_triangulator.sv */
// ----------------------------------------------------------------------------
// polygon_ear_clip_triangulator
// Ear clipping over a ring of shift cells.
//
//  channel | dir | fields
//  vtx_i   | in  | x_coord y_coord last_vertex
//  tri_o   | out | ax ay bx by cx cy last_triangle status
//
// Non-final vertices are taken back to back. Overflow and too-few status
// items are valid in the cycle after the final vertex. Triangulation aligns
// the ring, searches the minimum and sets the orientation, then tests each
// window, scans the ring when the tip is convex and advances on a reject.
// Output stalls hold the sequencer; no vertex is taken while a polygon runs.
// Reset clears all but the ring cells; those are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none
module polygon_ear_clip_triangulator
  import pect_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS = 16
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  pect_vtx_if.sink vtx_i,
  pect_tri_if.source tri_o
);
  localparam int CW = COORD_BITS;
  localparam int NB = $clog2(MAX_VERTICES + 1);
  localparam int PW = 2 * CW + 3;

  typedef enum logic [3:0] {
    S_LOAD, S_ALIGN, S_MIN, S_ORI, S_CONV, S_SCAN, S_EMIT, S_ADV, S_WAIT
  } state_e;

  // ring: cell 0 is the head. Window is cells 0,1,2 (first,second,third).
  logic signed [CW-1:0] rx [MAX_VERTICES];
  logic signed [CW-1:0] ry [MAX_VERTICES];
  cell_ctl_t ctl;
  state_e st_q;
  logic [NB-1:0] cnt_q, k_q, miss_q;
  logic ovf_q, cw_q, hit_q;
  logic signed [CW-1:0] lx_q, ly_q;
  logic signed [CW-1:0] mx_q, my_q, nx_q, ny_q, vx_q, vy_q;
  logic signed [CW-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
  logic signed [PW-1:0] cr_ori, cr_win, cr_ab, cr_bc, cr_ca;
  logic conv, hit, take, tok, adv_go, scan_end;

  function automatic logic signed [PW-1:0] xprod(
    input logic signed [CW-1:0] ox, input logic signed [CW-1:0] oy,
    input logic signed [CW-1:0] px, input logic signed [CW-1:0] py,
    input logic signed [CW-1:0] qx, input logic signed [CW-1:0] qy
  );
    logic signed [CW:0] d1x, d1y, d2x, d2y;
    logic signed [2*CW+1:0] m1, m2;
    d1x = (CW+1)'(px) - (CW+1)'(ox);
    d1y = (CW+1)'(py) - (CW+1)'(oy);
    d2x = (CW+1)'(qx) - (CW+1)'(ox);
    d2y = (CW+1)'(qy) - (CW+1)'(oy);
    m1 = d1x * d2y;
    m2 = d2x * d1y;
    return PW'(m1) - PW'(m2);
  endfunction

  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    logic signed [CW-1:0] nbx, nby, dx, dy;
    if (i == MAX_VERTICES - 1) begin : g_wrap
      assign nbx = rx[0];
      assign nby = ry[0];
    end else begin : g_next
      assign nbx = rx[i+1];
      assign nby = ry[i+1];
    end
    always_comb begin
      dx = nbx;
      dy = nby;
      if (ctl.load) begin
        dx = (NB'(i) == cnt_q) ? vtx_i.x_coord : rx[i];
        dy = (NB'(i) == cnt_q) ? vtx_i.y_coord : ry[i];
      end else if (ctl.drop && i == 0) begin
        dx = rx[i];
        dy = ry[i];
      end else if (ctl.shift && NB'(i) == cnt_q - NB'(1)) begin
        dx = rx[0];
        dy = ry[0];
      end
    end
    pect_cell #(.CW(CW)) u_cell (
      .clk_i, .ctl_i(ctl), .x_i(dx), .y_i(dy), .x_o(rx[i]), .y_o(ry[i])
    );
  end

  assign cr_ori = xprod(mx_q, my_q, nx_q, ny_q, vx_q, vy_q);
  assign cr_win = xprod(rx[0], ry[0], rx[1], ry[1], rx[2], ry[2]);
  assign cr_ab = xprod(rx[0], ry[0], ax_q, ay_q, bx_q, by_q);
  assign cr_bc = xprod(rx[0], ry[0], bx_q, by_q, cx_q, cy_q);
  assign cr_ca = xprod(rx[0], ry[0], cx_q, cy_q, ax_q, ay_q);

  assign conv = cw_q ? cr_win[PW-1] : (!cr_win[PW-1] && cr_win != '0);
  assign hit = (k_q >= NB'(3)) &&
               ((!cr_ab[PW-1] && cr_ab != '0 && !cr_bc[PW-1] && cr_bc != '0 &&
                 !cr_ca[PW-1] && cr_ca != '0) ||
                (cr_ab[PW-1] && cr_bc[PW-1] && cr_ca[PW-1]));
  assign take = vtx_i.valid && vtx_i.ready;
  assign tok = tri_o.valid && tri_o.ready;
  assign adv_go = (miss_q + NB'(1)) < cnt_q;
  assign scan_end = (k_q == cnt_q - NB'(1));
  assign vtx_i.ready = (st_q == S_LOAD) && !tri_o.valid;

  always_comb begin
    ctl = '0;
    ctl.load = take && (cnt_q < NB'(MAX_VERTICES));
    ctl.shift = (st_q == S_ALIGN) || (st_q == S_MIN) || (st_q == S_SCAN) ||
                (st_q == S_ADV && adv_go);
    ctl.drop = (st_q == S_EMIT) && tok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_LOAD; cnt_q <= '0; k_q <= '0; miss_q <= '0;
      ovf_q <= 1'b0; cw_q <= 1'b0; hit_q <= 1'b0;
      lx_q <= '0; ly_q <= '0; mx_q <= '0; my_q <= '0;
      nx_q <= '0; ny_q <= '0; vx_q <= '0; vy_q <= '0;
      ax_q <= '0; ay_q <= '0; bx_q <= '0; by_q <= '0; cx_q <= '0; cy_q <= '0;
      tri_o.valid <= 1'b0;
      tri_o.ax <= '0; tri_o.ay <= '0; tri_o.bx <= '0; tri_o.by <= '0;
      tri_o.cx <= '0; tri_o.cy <= '0; tri_o.last_triangle <= 1'b0;
      tri_o.status <= ST_TRI;
    end else begin
      if (ctl.shift) begin
        lx_q <= rx[0]; ly_q <= ry[0];
      end
      unique case (st_q)
        S_LOAD: if (take) begin
          if (cnt_q < NB'(MAX_VERTICES)) cnt_q <= cnt_q + NB'(1);
          else ovf_q <= 1'b1;
          if (vtx_i.last_vertex) begin
            tri_o.ax <= '0; tri_o.ay <= '0; tri_o.bx <= '0; tri_o.by <= '0;
            tri_o.cx <= '0; tri_o.cy <= '0; tri_o.last_triangle <= 1'b1;
            if (ovf_q || cnt_q >= NB'(MAX_VERTICES)) begin
              tri_o.status <= ST_OVER; tri_o.valid <= 1'b1; st_q <= S_WAIT;
            end else if (cnt_q < NB'(2)) begin
              tri_o.status <= ST_FEW; tri_o.valid <= 1'b1; st_q <= S_WAIT;
            end else begin
              k_q <= '0; st_q <= S_ALIGN;
            end
          end
        end
        // bring the last loaded vertex to the head
        S_ALIGN: begin
          if (k_q == cnt_q - NB'(2)) begin
            k_q <= '0; st_q <= S_MIN;
          end else k_q <= k_q + NB'(1);
        end
        // one full turn: track leftmost-lowest with its neighbors
        S_MIN: begin
          if (k_q == '0 || rx[0] < mx_q || (rx[0] == mx_q && ry[0] < my_q)) begin
            mx_q <= rx[0]; my_q <= ry[0]; nx_q <= rx[1]; ny_q <= ry[1];
            vx_q <= lx_q; vy_q <= ly_q;
          end
          if (scan_end) begin
            k_q <= '0; st_q <= S_ORI;
          end else k_q <= k_q + NB'(1);
        end
        S_ORI: begin
          cw_q <= cr_ori[PW-1]; miss_q <= '0; st_q <= S_CONV;
        end
        S_CONV: begin
          ax_q <= rx[0]; ay_q <= ry[0]; bx_q <= rx[1]; by_q <= ry[1];
          cx_q <= rx[2]; cy_q <= ry[2]; k_q <= '0; hit_q <= 1'b0;
          if (cnt_q == NB'(3)) begin
            tri_o.ax <= rx[0]; tri_o.ay <= ry[0]; tri_o.bx <= rx[1];
            tri_o.by <= ry[1]; tri_o.cx <= rx[2]; tri_o.cy <= ry[2];
            tri_o.last_triangle <= 1'b1; tri_o.status <= ST_TRI;
            tri_o.valid <= 1'b1; st_q <= S_WAIT;
          end else if (conv) st_q <= S_SCAN;
          else st_q <= S_ADV;
        end
        // one full turn: test every other vertex against the window
        S_SCAN: begin
          if (hit) hit_q <= 1'b1;
          if (scan_end) begin
            k_q <= '0;
            if (hit_q || hit) st_q <= S_ADV;
            else begin
              tri_o.ax <= ax_q; tri_o.ay <= ay_q; tri_o.bx <= bx_q;
              tri_o.by <= by_q; tri_o.cx <= cx_q; tri_o.cy <= cy_q;
              tri_o.last_triangle <= 1'b0; tri_o.status <= ST_TRI;
              tri_o.valid <= 1'b1; st_q <= S_EMIT;
            end
          end else k_q <= k_q + NB'(1);
        end
        S_EMIT: if (tok) begin
          tri_o.valid <= 1'b0;
          cnt_q <= cnt_q - NB'(1); miss_q <= '0; st_q <= S_CONV;
        end
        S_ADV: begin
          if (adv_go) begin
            miss_q <= miss_q + NB'(1); st_q <= S_CONV;
          end else begin
            tri_o.ax <= '0; tri_o.ay <= '0; tri_o.bx <= '0; tri_o.by <= '0;
            tri_o.cx <= '0; tri_o.cy <= '0; tri_o.last_triangle <= 1'b1;
            tri_o.status <= ST_NOEAR; tri_o.valid <= 1'b1; st_q <= S_WAIT;
          end
        end
        S_WAIT: if (tok) begin
          tri_o.valid <= 1'b0;
          cnt_q <= '0; ovf_q <= 1'b0; st_q <= S_LOAD;
        end
        default: st_q <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/core/pect_checker.sv */
// ----------------------------------------------------------------------------
// pect_checker
// Port-level checks of the triangulator.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module pect_checker
  import pect_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic out_last_i,
  input wire logic [1:0] out_status_i
);
  `ASSERT_CLK(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "valid dropped")
  `ASSERT_CLK(a_stable, clk_i, rst_ni, out_valid_i && !out_ready_i |=> $stable(out_status_i), "status moved")
  `ASSERT_NEVER(a_busy, clk_i, rst_ni, in_ready_i && out_valid_i, "input taken while result waits")
  `ASSERT_CLK(a_stlast, clk_i, rst_ni, out_valid_i && out_status_i != ST_TRI |-> out_last_i, "status not last")
endmodule
bind polygon_ear_clip_triangulator pect_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i(vtx_i.valid), .in_ready_i(vtx_i.ready),
  .out_valid_i(tri_o.valid), .out_ready_i(tri_o.ready),
  .out_last_i(tri_o.last_triangle), .out_status_i(tri_o.status)
);
`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Ear clipping triangulator check. Polygons are streamed one vertex per item
// through the vertex channel. Every accepted vertex feeds a behavioral ring
// model that predicts the triangles and status items. Each item on the
// triangle channel is compared field by field with the oldest prediction.
// Both channels idle at random unless calm is set.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  import pect_pkg::*;

  localparam int NV = 64;
  localparam int STALL_LIMIT = 40000;

  typedef struct packed {
    logic signed [15:0] ax, ay, bx, by, cx, cy;
    logic last;
    status_e st;
  } tri_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pect_vtx_if #(16) vtx_ch ();
  pect_tri_if #(16) tri_ch ();

  polygon_ear_clip_triangulator #(.MAX_VERTICES(NV), .COORD_BITS(16))
    dut (clk_i, rst_ni, vtx_ch, tri_ch);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ring model
  longint px[NV];
  longint py[NV];
  int nxt[NV];
  int prv[NV];
  int ring_count;
  int ring_cur;
  bit ring_over;

  tri_item_t tri_expect_q[$];
  int mismatches = 0;
  bit calm;
  int stall_cycles = 0;

  function automatic longint turn(int o, int p, int q);
    return (px[p] - px[o]) * (py[q] - py[o]) - (px[q] - px[o]) * (py[p] - py[o]);
  endfunction

  function automatic void push_tri(int a, int b, int c, bit last);
    tri_item_t t;
    t.ax = 16'(px[a]); t.ay = 16'(py[a]); t.bx = 16'(px[b]); t.by = 16'(py[b]);
    t.cx = 16'(px[c]); t.cy = 16'(py[c]); t.last = last; t.st = ST_TRI;
    tri_expect_q = {tri_expect_q, t};
  endfunction

  function automatic void push_status(status_e s);
    tri_item_t t;
    t = '0;
    t.last = 1'b1;
    t.st = s;
    tri_expect_q = {tri_expect_q, t};
  endfunction

  function automatic bit point_blocks_ear(int a, int b, int c);
    int t;
    longint p, q, r;
    t = ring_cur;
    for (int n = 0; n < ring_count; n++) begin
      if (t != a && t != b && t != c) begin
        p = turn(t, a, b);
        q = turn(t, b, c);
        r = turn(t, c, a);
        if ((p > 0 && q > 0 && r > 0) || (p < 0 && q < 0 && r < 0)) return 1'b1;
      end
      t = nxt[t];
    end
    return 1'b0;
  endfunction

  function automatic void ear_clip_polygon();
    int f, s, t, mn, misses, w;
    bit cw, convex;
    longint pr;
    f = ring_cur; s = nxt[f]; t = nxt[s];
    mn = ring_cur; misses = 0; w = ring_cur;
    for (int n = 0; n < ring_count; n++) begin
      if (px[w] < px[mn] || (px[w] == px[mn] && py[w] < py[mn])) mn = w;
      w = nxt[w];
    end
    cw = turn(mn, nxt[mn], prv[mn]) < 0;
    while (ring_count > 3) begin
      pr = turn(f, s, t);
      convex = cw ? (pr < 0) : (pr > 0);
      if (convex && !point_blocks_ear(f, s, t)) begin
        push_tri(f, s, t, 1'b0);
        if (s == ring_cur) ring_cur = prv[s];
        nxt[f] = t;
        prv[t] = f;
        ring_count--;
        misses = 0;
        s = t;
        t = nxt[t];
      end else begin
        misses++;
        if (misses >= ring_count) begin
          push_status(ST_NOEAR);
          return;
        end
        f = s; s = t; t = nxt[t];
      end
    end
    push_tri(f, s, t, 1'b1);
  endfunction

  function automatic void accept_vertex(logic signed [15:0] x, logic signed [15:0] y,
                                        bit last);
    int idx, nx;
    if (ring_count >= NV) begin
      ring_over = 1'b1;
    end else begin
      idx = ring_count;
      px[idx] = x;
      py[idx] = y;
      if (idx == 0) begin
        nxt[0] = 0; prv[0] = 0;
      end else begin
        nx = nxt[ring_cur];
        nxt[idx] = nx;
        prv[idx] = ring_cur;
        nxt[ring_cur] = idx;
        prv[nx] = idx;
      end
      ring_cur = idx;
      ring_count++;
    end
    if (!last) return;
    if (ring_over) push_status(ST_OVER);
    else if (ring_count < 3) push_status(ST_FEW);
    else ear_clip_polygon();
    ring_count = 0;
    ring_cur = 0;
    ring_over = 1'b0;
  endfunction

  task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y, bit last);
    if (!calm) begin
      while ($urandom_range(99) < 7) begin
        vtx_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    vtx_ch.valid <= 1'b1;
    vtx_ch.x_coord <= x;
    vtx_ch.y_coord <= y;
    vtx_ch.last_vertex <= last;
    do @(posedge clk_i); while (!vtx_ch.ready);
    accept_vertex(x, y, last);
  endtask

  task automatic hold_off();
    vtx_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    hold_off();
    wait (tri_expect_q.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  // star-shaped polygon around the origin, hence simple
  task automatic send_star(int n, int rmax, bit cw);
    real a;
    int r;
    for (int i = 0; i < n; i++) begin
      a = 6.2831853 * (real'(i) + $urandom_range(80) / 100.0) / n;
      if (cw) a = -a;
      r = $urandom_range(rmax, rmax / 8 + 1);
      send_vertex(16'($rtoi(r * $cos(a))), 16'($rtoi(r * $sin(a))), i == n - 1);
    end
  endtask

  task automatic test_few_vertices();
    send_vertex(16'sd5, -16'sd7, 1'b1);
    send_vertex(16'sd1, 16'sd2, 1'b0);
    send_vertex(16'sd3, 16'sd4, 1'b1);
  endtask

  task automatic test_directed_shapes();
    // extreme triangle
    send_vertex(16'sh8000, 16'sh8000, 1'b0);
    send_vertex(16'sd32767, 16'sh8000, 1'b0);
    send_vertex(16'sd32767, 16'sd32767, 1'b1);
    // square, clockwise
    send_vertex(16'sh8000, 16'sd32767, 1'b0);
    send_vertex(16'sd32767, 16'sd32767, 1'b0);
    send_vertex(16'sd32767, 16'sh8000, 1'b0);
    send_vertex(16'sh8000, 16'sh8000, 1'b1);
    // concave arrow with a collinear tip
    send_vertex(16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd10, 16'sd0, 1'b0);
    send_vertex(16'sd20, 16'sd0, 1'b0);
    send_vertex(16'sd20, 16'sd20, 1'b0);
    send_vertex(16'sd10, 16'sd5, 1'b0);
    send_vertex(16'sd0, 16'sd20, 1'b1);
    // all collinear: no ear
    send_vertex(16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd1, 16'sd1, 1'b0);
    send_vertex(16'sd2, 16'sd2, 1'b0);
    send_vertex(16'sd3, 16'sd3, 1'b1);
  endtask

  task automatic test_full_store();
    send_star(NV, 30000, 1'b0);
  endtask

  task automatic test_overflow();
    for (int i = 0; i <= NV; i++)
      send_vertex(16'($urandom), 16'($urandom), i == NV);
  endtask

  task automatic test_random_polygons();
    int sent;
    int n;
    sent = 0;
    while (sent < 140) begin
      calm = (sent > 40 && sent < 100);
      n = $urandom_range(12, 3);
      if ($urandom_range(9) < 8) begin
        send_star(n, ($urandom_range(9) < 3) ? 32000 : int'($urandom_range(200, 4)),
                  1'($urandom_range(1)));
      end else begin
        for (int i = 0; i < n; i++)
          send_vertex(16'($urandom), 16'($urandom), i == n - 1);
      end
      sent += n;
    end
    calm = 1'b0;
  endtask

  always @(posedge clk_i) begin
    tri_ch.ready <= calm || $urandom_range(99) >= 7;
  end

  always @(posedge clk_i) begin
    tri_item_t exp_t, got;
    if (tri_ch.valid && tri_ch.ready) begin
      got.ax = tri_ch.ax; got.ay = tri_ch.ay; got.bx = tri_ch.bx;
      got.by = tri_ch.by; got.cx = tri_ch.cx; got.cy = tri_ch.cy;
      got.last = tri_ch.last_triangle;
      got.st = status_e'(tri_ch.status);
      if (tri_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected triangle item %p", got);
      end else begin
        exp_t = tri_expect_q.pop_front();
        if (got !== exp_t) begin
          mismatches++;
          if (mismatches <= 10) $display("expected %p got %p", exp_t, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((vtx_ch.valid && vtx_ch.ready) || (tri_ch.valid && tri_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles > STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    vtx_ch.valid = 1'b0;
    vtx_ch.x_coord = '0;
    vtx_ch.y_coord = '0;
    vtx_ch.last_vertex = 1'b0;
    ring_count = 0;
    ring_cur = 0;
    ring_over = 1'b0;
    calm = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_few_vertices();
    test_directed_shapes();
    drain();
    test_full_store();
    test_overflow();
    test_random_polygons();
    drain();
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && tri_expect_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
+incdir+rtl/core
rtl/core/pect_pkg.sv
rtl/core/pect_if.sv
rtl/core/pect_cell.sv
rtl/core/polygon_ear_clip_triangulator.sv
rtl/core/pect_checker.sv
tb/testbench.sv
